/* rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg - shared types and codes of the frame allocator
// Action and status codes, the classified command that travels from the
// front end to the back end, and the control group between the two.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    // Field widths fixed by the stream format
    localparam int ACTION_W = 3;
    localparam int FRAME_W  = 15;
    localparam int WORD_W   = 16;
    localparam int STATUS_W = 2;

    // Action codes on the input stream
    localparam logic [ACTION_W-1:0] ACT_INIT          = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC         = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE_TABLE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_GET_REF       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ENTRY_UPDATE  = 3'd5;

    // Status codes on the result stream
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RESERVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_BUSY = 2'd3;

    // Command queue geometry
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PW    = 1;
    localparam int FQ_CW    = 2;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_ALLOC,
        OP_RELEASE,
        OP_RELEASE_TABLE,
        OP_GET_REF,
        OP_ENTRY_UPDATE,
        OP_NOP
    } op_t;

    // Classified command
    typedef struct packed {
        op_t                op;
        logic [FRAME_W-1:0] frame;
        logic               in_range;       // frame exists in the word store
        logic               below_reserved; // frame is in the reserved range
        logic               count_up;       // entry valid bit turns on
        logic               count_down;     // entry valid bit turns off
    } cmd_t;

    // Queue head seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fq_head_t;

    // Back end control toward the front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

`default_nettype wire

/* rtl/ffa_ram.sv */
// ----------------------------------------------------------------------------
// ffa_ram - generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/ffa_front.sv */
// ----------------------------------------------------------------------------
// ffa_front - input front end of the frame allocator
// Accepts input transactions, classifies each action against the frame
// range and the reserved boundary, and queues the command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_front #(
    parameter int TOTAL_FRAMES = 32768
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ffa_pkg::WORD_W-1:0]      reserved_frames,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ffa_pkg::ACTION_W-1:0]    s_action,
    input  wire logic [ffa_pkg::FRAME_W-1:0]     s_frame,
    input  wire logic                            s_old_valid,
    input  wire logic                            s_new_valid,
    input  wire ffa_pkg::back_ctl_t              ctl,
    output ffa_pkg::fq_head_t                    q_head
);

    localparam logic [16:0] TOTAL_17 = 17'(TOTAL_FRAMES);

    ffa_pkg::cmd_t                  cmd_in;
    ffa_pkg::cmd_t                  q_entry_reg [ffa_pkg::FQ_DEPTH];
    logic [ffa_pkg::FQ_PW-1:0]      wr_ptr_reg;
    logic [ffa_pkg::FQ_PW-1:0]      wr_ptr_next;
    logic [ffa_pkg::FQ_PW-1:0]      rd_ptr_reg;
    logic [ffa_pkg::FQ_PW-1:0]      rd_ptr_next;
    logic [ffa_pkg::FQ_CW-1:0]      count_reg;
    logic [ffa_pkg::FQ_CW-1:0]      count_next;
    logic                           accept;
    logic                           pop;

    // Classify the incoming action
    always_comb
    begin
        cmd_in.frame          = s_frame;
        cmd_in.in_range       = {2'b00, s_frame} < TOTAL_17;
        cmd_in.below_reserved = {1'b0, s_frame} < reserved_frames;
        cmd_in.count_up       = s_new_valid && !s_old_valid;
        cmd_in.count_down     = !s_new_valid && s_old_valid;
        unique case (s_action)
            ffa_pkg::ACT_INIT:          cmd_in.op = ffa_pkg::OP_INIT;
            ffa_pkg::ACT_ALLOC:         cmd_in.op = ffa_pkg::OP_ALLOC;
            ffa_pkg::ACT_RELEASE:       cmd_in.op = ffa_pkg::OP_RELEASE;
            ffa_pkg::ACT_RELEASE_TABLE: cmd_in.op = ffa_pkg::OP_RELEASE_TABLE;
            ffa_pkg::ACT_GET_REF:       cmd_in.op = ffa_pkg::OP_GET_REF;
            ffa_pkg::ACT_ENTRY_UPDATE:  cmd_in.op = ffa_pkg::OP_ENTRY_UPDATE;
            default:                    cmd_in.op = ffa_pkg::OP_NOP;
        endcase
    end

    // Hold off input while the queue is full or the store is being cleared
    assign s_tready = (count_reg != ffa_pkg::FQ_CW'(ffa_pkg::FQ_DEPTH)) && !ctl.clearing;
    assign accept   = s_tvalid && s_tready;
    assign pop      = ctl.pop && (count_reg != '0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.cmd   = q_entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* rtl/ffa_back.sv */
// ----------------------------------------------------------------------------
// ffa_back - execution back end of the frame allocator
// Owns the frame word store, the free list head and the free count. Clears
// the store after reset, walks the free list on init, and runs every other
// command as a store read followed by an update and a load of the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_back #(
    parameter int TOTAL_FRAMES = 32768,
    parameter int LIST_STRIDE  = 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ffa_pkg::WORD_W-1:0]      reserved_frames,
    input  wire ffa_pkg::fq_head_t               q_head,
    output ffa_pkg::back_ctl_t                   ctl,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ffa_pkg::STATUS_W-1:0]         m_status,
    output logic [ffa_pkg::FRAME_W-1:0]          m_granted_frame,
    output logic [ffa_pkg::WORD_W-1:0]           m_ref_count,
    output logic [ffa_pkg::WORD_W-1:0]           m_free_frames
);

    localparam int AW = (TOTAL_FRAMES > 1) ? $clog2(TOTAL_FRAMES) : 1;
    localparam int PW = $clog2(TOTAL_FRAMES + LIST_STRIDE + 1);
    localparam int JW = (LIST_STRIDE > 1) ? $clog2(LIST_STRIDE) : 1;
    localparam logic [16:0]   TOTAL_17  = 17'(TOTAL_FRAMES);
    localparam logic [PW-1:0] TOTAL_P   = PW'(TOTAL_FRAMES);
    localparam logic [PW-1:0] STRIDE_P  = PW'(LIST_STRIDE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL_FRAMES - 1);
    localparam logic [JW-1:0] LAST_J    = JW'(LIST_STRIDE - 1);

    typedef enum logic [3:0] {
        BS_CLEAR = 4'b0001,
        BS_IDLE  = 4'b0010,
        BS_WALK  = 4'b0100,
        BS_EXEC  = 4'b1000
    } back_state_t;

    back_state_t                    state_reg, state_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [ffa_pkg::FRAME_W-1:0]    head_reg, head_next;
    logic [ffa_pkg::WORD_W-1:0]     free_reg, free_next;
    ffa_pkg::cmd_t                  cmd_reg, cmd_next;
    logic                           rd_ok_reg, rd_ok_next;
    logic [PW-1:0]                  walk_reg, walk_next;
    logic [PW-1:0]                  chain_reg, chain_next;
    logic [JW-1:0]                  j_reg, j_next;
    logic                           out_valid_reg, out_valid_next;
    logic [ffa_pkg::STATUS_W-1:0]   out_status_reg;
    logic [ffa_pkg::FRAME_W-1:0]    out_granted_reg;
    logic [ffa_pkg::WORD_W-1:0]     out_ref_reg;
    logic [ffa_pkg::WORD_W-1:0]     out_free_reg;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [ffa_pkg::WORD_W-1:0]     mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;
    logic [ffa_pkg::WORD_W-1:0]     mem_rdata;

    logic [ffa_pkg::WORD_W-1:0]     rd_word;
    logic                           out_load;
    logic                           out_free;
    logic                           base_ok;
    logic                           head_ok;
    logic [PW-1:0]                  walk_step;
    logic [PW-1:0]                  chain_inc;
    logic                           walk_more;
    logic                           last_chain;
    logic [ffa_pkg::WORD_W-1:0]     walk_data;

    logic [ffa_pkg::STATUS_W-1:0]   ex_status;
    logic [ffa_pkg::FRAME_W-1:0]    ex_granted;
    logic [ffa_pkg::WORD_W-1:0]     ex_ref;
    logic [ffa_pkg::WORD_W-1:0]     ex_free;
    logic [ffa_pkg::FRAME_W-1:0]    ex_head;
    logic                           ex_we;
    logic [AW-1:0]                  ex_addr;
    logic [ffa_pkg::WORD_W-1:0]     ex_data;
    logic                           ex_release;

    ffa_ram #(
        .WIDTH (ffa_pkg::WORD_W),
        .DEPTH (TOTAL_FRAMES)
    ) u_words (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Words beyond the store read as zero
    assign rd_word  = rd_ok_reg ? mem_rdata : '0;
    assign out_free = !out_valid_reg || m_tready;
    assign base_ok  = {1'b0, reserved_frames} < TOTAL_17;
    assign head_ok  = {2'b00, head_reg} < TOTAL_17;

    // Init walk: link in stride order, close each chain onto the next one
    assign walk_step  = walk_reg + STRIDE_P;
    assign chain_inc  = chain_reg + PW'(1);
    assign walk_more  = walk_step < TOTAL_P;
    assign last_chain = (j_reg == LAST_J) || (chain_inc >= TOTAL_P);
    always_comb
    begin
        if (walk_more)
        begin
            walk_data = ffa_pkg::WORD_W'(walk_step);
        end
        else if (last_chain)
        begin
            walk_data = '0;
        end
        else
        begin
            walk_data = ffa_pkg::WORD_W'(chain_inc);
        end
    end

    // Execute the command using the word read when the command was taken
    always_comb
    begin
        ex_status  = ffa_pkg::ST_OK;
        ex_granted = '0;
        ex_ref     = '0;
        ex_free    = free_reg;
        ex_head    = head_reg;
        ex_we      = 1'b0;
        ex_addr    = AW'(cmd_reg.frame);
        ex_data    = '0;
        ex_release = 1'b0;
        unique case (cmd_reg.op)
            ffa_pkg::OP_INIT:
            begin
            end
            ffa_pkg::OP_ALLOC:
            begin
                if (free_reg == '0)
                begin
                    ex_status = ffa_pkg::ST_NO_FRAME;
                end
                else
                begin
                    ex_granted = head_reg;
                    ex_head    = rd_word[ffa_pkg::FRAME_W-1:0];
                    ex_we      = head_ok;
                    ex_addr    = AW'(head_reg);
                    ex_free    = free_reg - 1'b1;
                end
            end
            ffa_pkg::OP_RELEASE:
            begin
                ex_release = 1'b1;
            end
            ffa_pkg::OP_RELEASE_TABLE:
            begin
                if (rd_word != '0)
                begin
                    ex_status = ffa_pkg::ST_TABLE_BUSY;
                    ex_ref    = rd_word;
                end
                else
                begin
                    ex_release = 1'b1;
                end
            end
            ffa_pkg::OP_GET_REF:
            begin
                ex_ref = rd_word;
            end
            ffa_pkg::OP_ENTRY_UPDATE:
            begin
                ex_ref = rd_word;
                if (cmd_reg.in_range && (cmd_reg.count_up || cmd_reg.count_down))
                begin
                    ex_we   = 1'b1;
                    ex_data = cmd_reg.count_up ? rd_word + 1'b1 : rd_word - 1'b1;
                    ex_ref  = ex_data;
                end
            end
            ffa_pkg::OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        // Push the frame, or refuse it when reserved or outside the store
        if (ex_release)
        begin
            if (cmd_reg.below_reserved || !cmd_reg.in_range)
            begin
                ex_status = ffa_pkg::ST_RESERVED;
                ex_ref    = rd_word;
            end
            else
            begin
                ex_we   = 1'b1;
                ex_data = {1'b0, head_reg};
                ex_head = cmd_reg.frame;
                ex_free = free_reg + 1'b1;
                ex_ref  = {1'b0, head_reg};
            end
        end
    end

    // Sequence: clear, take command, walk or read, execute
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        cmd_next     = cmd_reg;
        rd_ok_next   = rd_ok_reg;
        walk_next    = walk_reg;
        chain_next   = chain_reg;
        j_next       = j_reg;
        mem_we       = 1'b0;
        mem_waddr    = clr_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = AW'(q_head.cmd.frame);
        out_load     = 1'b0;
        ctl.pop      = 1'b0;
        ctl.clearing = (state_reg == BS_CLEAR);
        unique case (state_reg)
            BS_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (q_head.valid)
                begin
                    ctl.pop    = 1'b1;
                    cmd_next   = q_head.cmd;
                    mem_re     = 1'b1;
                    rd_ok_next = q_head.cmd.in_range;
                    state_next = BS_EXEC;
                    if (q_head.cmd.op == ffa_pkg::OP_ALLOC)
                    begin
                        mem_raddr  = AW'(head_reg);
                        rd_ok_next = head_ok;
                    end
                    if (q_head.cmd.op == ffa_pkg::OP_INIT)
                    begin
                        if (base_ok)
                        begin
                            head_next  = reserved_frames[ffa_pkg::FRAME_W-1:0];
                            free_next  = ffa_pkg::WORD_W'(TOTAL_17 - {1'b0, reserved_frames});
                            walk_next  = PW'(reserved_frames);
                            chain_next = PW'(reserved_frames);
                            j_next     = '0;
                            state_next = BS_WALK;
                        end
                        else
                        begin
                            free_next = '0;
                        end
                    end
                end
            end
            BS_WALK:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(walk_reg);
                mem_wdata = walk_data;
                if (walk_more)
                begin
                    walk_next = walk_step;
                end
                else if (last_chain)
                begin
                    state_next = BS_EXEC;
                end
                else
                begin
                    chain_next = chain_inc;
                    walk_next  = chain_inc;
                    j_next     = j_reg + 1'b1;
                end
            end
            BS_EXEC:
            begin
                if (out_free)
                begin
                    mem_we     = ex_we;
                    mem_waddr  = ex_addr;
                    mem_wdata  = ex_data;
                    head_next  = ex_head;
                    free_next  = ex_free;
                    out_load   = 1'b1;
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Result register: drop on transfer, load on execute
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and walk payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        rd_ok_reg <= rd_ok_next;
        walk_reg  <= walk_next;
        chain_reg <= chain_next;
        j_reg     <= j_next;
        if (out_load)
        begin
            out_status_reg  <= ex_status;
            out_granted_reg <= ex_granted;
            out_ref_reg     <= ex_ref;
            out_free_reg    <= ex_free;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_granted_frame = out_granted_reg;
    assign m_ref_count     = out_ref_reg;
    assign m_free_frames   = out_free_reg;

endmodule

`default_nettype wire

/* rtl/free_frame_allocator_with_refcount.sv */
// ----------------------------------------------------------------------------
// free_frame_allocator_with_refcount - page frame allocator top level
// Free list of page frames with a per-frame valid-entry count that shares
// the frame's link word.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: frame, valid bits
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: grant, count, free
// cfg_*     in   cfg_wr_en          reserved frame boundary, no read-back
//
// Each command other than init runs in the back end as one word store read,
// then one update and result load, which waits while the result register
// holds an untaken result. Init makes one store write per free frame. After
// reset the store is cleared one word per cycle while s_tready stays low. A
// two-entry command queue and the result register let input and output
// stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module free_frame_allocator_with_refcount #(
    parameter int TOTAL_FRAMES = 32768,
    parameter int LIST_STRIDE  = 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // frame_number[14:0], old_valid, new_valid
    input  wire logic [2:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0] m_tdata,   // granted_frame[14:0], ref_count[15:0], free_frames[15:0]
    output logic [1:0]       m_tuser,   // status
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data // reserved_frames
);

    localparam logic [ffa_pkg::WORD_W-1:0] RESERVED_RESET = 16'd1024;

    logic [ffa_pkg::WORD_W-1:0]     reserved_reg;
    logic [ffa_pkg::WORD_W-1:0]     reserved_next;
    ffa_pkg::fq_head_t              q_head;
    ffa_pkg::back_ctl_t             ctl;
    logic [ffa_pkg::STATUS_W-1:0]   m_status;
    logic [ffa_pkg::FRAME_W-1:0]    m_granted_frame;
    logic [ffa_pkg::WORD_W-1:0]     m_ref_count;
    logic [ffa_pkg::WORD_W-1:0]     m_free_frames;

    // Reserved frame boundary register
    assign reserved_next = cfg_wr_en ? cfg_wr_data : reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= RESERVED_RESET;
        end
        else
        begin
            reserved_reg <= reserved_next;
        end
    end

    ffa_front #(
        .TOTAL_FRAMES (TOTAL_FRAMES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .reserved_frames (reserved_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_action        (s_tuser),
        .s_frame         (s_tdata[14:0]),
        .s_old_valid     (s_tdata[15]),
        .s_new_valid     (s_tdata[16]),
        .ctl             (ctl),
        .q_head          (q_head)
    );

    ffa_back #(
        .TOTAL_FRAMES (TOTAL_FRAMES),
        .LIST_STRIDE  (LIST_STRIDE)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .reserved_frames (reserved_reg),
        .q_head          (q_head),
        .ctl             (ctl),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_status        (m_status),
        .m_granted_frame (m_granted_frame),
        .m_ref_count     (m_ref_count),
        .m_free_frames   (m_free_frames)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {1'b0, m_free_frames, m_ref_count, m_granted_frame};
    assign m_tuser = m_status;

endmodule

`default_nettype wire
